// File: rtl/rrss_pkg.sv
// ----------------------------------------------------------------------------
// rrss_pkg
// Types and constants shared by the round-robin slice scheduler modules.
// ----------------------------------------------------------------------------
package rrss_pkg;

   localparam logic       OP_ADD      = 1'b0;
   localparam logic       OP_DISPATCH = 1'b1;

   localparam logic [1:0] ST_ADDED = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_RUN   = 2'd2;
   localparam logic [1:0] ST_EMPTY = 2'd3;

   localparam int         ID_W        = 8;
   localparam int         TIME_W      = 16;
   localparam logic [TIME_W-1:0] SLICE_RESET = 16'd10;

   // one queued request between front and back
   typedef struct packed {
      logic              opcode;
      logic [ID_W-1:0]   task_id;
      logic [TIME_W-1:0] burst_time;
   } cmd_type;

   // handshake from front to back
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_chan_type;

endpackage

// File: rtl/rrss_front.sv
// ----------------------------------------------------------------------------
// rrss_front
// Request intake: a two-entry queue that decouples the request port from
// the task engine.
// ----------------------------------------------------------------------------
module rrss_front import rrss_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_opcode,
   input  logic [ID_W-1:0]     req_task_id,
   input  logic [TIME_W-1:0]   req_burst_time,
   output cmd_chan_type        cmd_chan,
   input  logic                cmd_pop
);

   cmd_type     entry_ff [2];
   logic        wr_ptr_ff;
   logic        rd_ptr_ff;
   logic [1:0]  count_ff;
   logic [1:0]  count_in;
   logic        push;

   assign req_stall      = (count_ff == 2'd2);
   assign push           = req_valid && !req_stall;
   assign cmd_chan.valid = (count_ff != 2'd0);
   assign cmd_chan.cmd   = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !cmd_pop) begin
         count_in = count_ff + 2'd1;
      end else if (!push && cmd_pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (cmd_pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= '{opcode: req_opcode, task_id: req_task_id,
                                  burst_time: req_burst_time};
      end
   end

endmodule

// File: rtl/rrss_back.sv
// ----------------------------------------------------------------------------
// rrss_back
// Task engine: ready-task ring in memory, slice computation, result register.
// ----------------------------------------------------------------------------
module rrss_back import rrss_pkg::*; #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic [TIME_W-1:0]             csr_write_data,
   input  cmd_chan_type                  cmd_chan,
   output logic                          cmd_pop,
   output logic [$clog2(QUEUE_DEPTH+1)-1:0] occupancy,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_status,
   output logic [ID_W-1:0]               rsp_run_id,
   output logic [TIME_W-1:0]             rsp_run_amount,
   output logic                          rsp_finished
);

   localparam int ADDR_W  = $clog2(QUEUE_DEPTH);
   localparam int OCC_W   = $clog2(QUEUE_DEPTH + 1);
   localparam int ENTRY_W = ID_W + TIME_W;

   typedef enum logic {S_IDLE, S_READ} state_type;

   logic [ENTRY_W-1:0] mem [QUEUE_DEPTH];
   logic [ENTRY_W-1:0] rd_data_ff;

   state_type          state_ff, state_in;
   logic [ADDR_W-1:0]  head_ff, head_in;
   logic [ADDR_W-1:0]  tail_ff, tail_in;
   logic [OCC_W-1:0]   occ_ff, occ_in;
   logic [TIME_W-1:0]  slice_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         status_ff, status_in;
   logic [ID_W-1:0]    run_id_ff, run_id_in;
   logic [TIME_W-1:0]  run_amount_ff, run_amount_in;
   logic               finished_ff, finished_in;

   logic               mem_we;
   logic [ENTRY_W-1:0] mem_wdata;
   logic               out_free;
   logic [TIME_W-1:0]  rem;
   logic [TIME_W-1:0]  run;
   logic [TIME_W-1:0]  left;
   logic [ADDR_W-1:0]  tail_next;
   logic [ADDR_W-1:0]  head_next;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign tail_next = (tail_ff == ADDR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + 1'b1;
   assign head_next = (head_ff == ADDR_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;

   // slice arithmetic on the entry read at the head
   assign rem  = rd_data_ff[TIME_W-1:0];
   assign run  = (rem > slice_ff) ? slice_ff : rem;
   assign left = rem - run;

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      occ_in        = occ_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      status_in     = status_ff;
      run_id_in     = run_id_ff;
      run_amount_in = run_amount_ff;
      finished_in   = finished_ff;
      cmd_pop       = 1'b0;
      mem_we        = 1'b0;
      mem_wdata     = {cmd_chan.cmd.task_id, cmd_chan.cmd.burst_time};

      unique case (state_ff)
         S_IDLE: begin
            if (cmd_chan.valid && out_free) begin
               cmd_pop       = 1'b1;
               run_id_in     = '0;
               run_amount_in = '0;
               finished_in   = 1'b0;
               if (cmd_chan.cmd.opcode == OP_ADD) begin
                  rsp_valid_in = 1'b1;
                  if (occ_ff == OCC_W'(QUEUE_DEPTH)) begin
                     status_in = ST_FULL;
                  end else begin
                     mem_we    = 1'b1;
                     tail_in   = tail_next;
                     occ_in    = occ_ff + 1'b1;
                     status_in = ST_ADDED;
                  end
               end else if (occ_ff == '0) begin
                  rsp_valid_in = 1'b1;
                  status_in    = ST_EMPTY;
               end else begin
                  // head entry is captured in the read register, result is formed in S_READ
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            state_in      = S_IDLE;
            rsp_valid_in  = 1'b1;
            status_in     = ST_RUN;
            run_id_in     = rd_data_ff[ENTRY_W-1:TIME_W];
            run_amount_in = run;
            finished_in   = (left == '0);
            head_in       = head_next;
            if (left != '0) begin
               // unfinished task goes back to the tail, occupancy unchanged
               mem_we    = 1'b1;
               mem_wdata = {rd_data_ff[ENTRY_W-1:TIME_W], left};
               tail_in   = tail_next;
            end else begin
               occ_in = occ_ff - 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         occ_ff       <= '0;
         slice_ff     <= SLICE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            slice_ff <= csr_write_data;
         end
      end
      status_ff     <= status_in;
      run_id_ff     <= run_id_in;
      run_amount_ff <= run_amount_in;
      finished_ff   <= finished_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[tail_ff] <= mem_wdata;
      end
      rd_data_ff <= mem[head_ff];
   end

   assign occupancy      = occ_ff;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_run_id     = run_id_ff;
   assign rsp_run_amount = run_amount_ff;
   assign rsp_finished   = finished_ff;

endmodule

// File: rtl/round_robin_slice_scheduler_top.sv
// response path: an add request's response is registered straight from the
// idle state, a dispatch's after S_READ (registered read of the task memory).
// throughput: one add per cycle unless rsp_stall holds the response; a dispatch
// waits in S_READ on the single read port; a two-entry request queue absorbs it.
// reset: synchronous, clears queue pointers and counts, slice length to 10.
// ----------------------------------------------------------------------------
// round_robin_slice_scheduler_top
// Round-robin dispatcher over a FIFO of ready tasks with a programmable time slice.
// ----------------------------------------------------------------------------
module round_robin_slice_scheduler_top import rrss_pkg::*; #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_enable,
   input  logic [TIME_W-1:0]   csr_write_data,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_opcode,
   input  logic [ID_W-1:0]     req_task_id,
   input  logic [TIME_W-1:0]   req_burst_time,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          rsp_status,
   output logic [ID_W-1:0]     rsp_run_id,
   output logic [TIME_W-1:0]   rsp_run_amount,
   output logic                rsp_finished
);

   localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

   cmd_chan_type     cmd_chan;
   logic             cmd_pop;
   logic [OCC_W-1:0] occupancy;

   rrss_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_opcode     (req_opcode),
      .req_task_id    (req_task_id),
      .req_burst_time (req_burst_time),
      .cmd_chan       (cmd_chan),
      .cmd_pop        (cmd_pop)
   );

   rrss_back #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .cmd_chan         (cmd_chan),
      .cmd_pop          (cmd_pop),
      .occupancy        (occupancy),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_run_id       (rsp_run_id),
      .rsp_run_amount   (rsp_run_amount),
      .rsp_finished     (rsp_finished)
   );

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occupancy <= OCC_W'(QUEUE_DEPTH))
      else $error("task queue occupancy above depth");

   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cmd_chan.valid)
      else $error("engine popped an empty request queue");

   a_idle_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_RUN |->
         rsp_run_id == '0 && rsp_run_amount == '0 && !rsp_finished)
      else $error("run fields set on a non-dispatch response");

endmodule
